// ----- rtl/mwm_pkg.sv -----
// ----------------------------------------------------------------------------
// mwm_pkg
// Shared constants and types for the mecanum wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package mwm_pkg;

  // default datapath sizes
  localparam int IN_WIDTH_DEF  = 16;
  localparam int FRAC_BITS_DEF = 12;

  // configuration register widths
  localparam int SCALE_W = 12;
  localparam int DUTY_W  = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = SCALE_W;

  // number of wheels
  localparam int NWHEEL = 4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEAD_OFFSET = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_LIMIT  = 2'd2;

  // register reset values
  localparam logic [SCALE_W-1:0] SPEED_SCALE_RST = 12'd1000;
  localparam logic [DUTY_W-1:0]  DEAD_OFFSET_RST = 8'd40;
  localparam logic [DUTY_W-1:0]  DUTY_LIMIT_RST  = 8'd250;

  // control that travels with each item down the pipeline
  typedef struct packed {
    logic              valid;
    logic [NWHEEL-1:0] neg;
    logic              moving;
  } side_t;

endpackage

`default_nettype wire

// ----- rtl/mwm_mix.sv -----
// ----------------------------------------------------------------------------
// mwm_mix
// Front end: wheel sums, magnitudes, peak search, scale product and divisor.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_mix #(
  parameter int IN_WIDTH  = mwm_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF,
  parameter int MW        = IN_WIDTH + 1,
  parameter int DW        = (IN_WIDTH + 1 > FRAC_BITS + 1) ? IN_WIDTH + 1 : FRAC_BITS + 1
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst_n,
  input  wire logic                                    in_take,
  input  wire logic signed [IN_WIDTH-1:0]              vel_x,
  input  wire logic signed [IN_WIDTH-1:0]              vel_y,
  input  wire logic signed [IN_WIDTH-1:0]              yaw_rate,
  input  wire logic [mwm_pkg::SCALE_W-1:0]             speed_scale,
  output mwm_pkg::side_t                               side_o,
  output logic [DW-1:0]                                div_o,
  output logic [mwm_pkg::NWHEEL-1:0][DW-1:0]           rem_o,
  output logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::SCALE_W-1:0] lo_o
);

  localparam int WW = IN_WIDTH + 2;
  localparam int PW = MW + mwm_pkg::SCALE_W;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // stage 1: raw wheel sums
  mwm_pkg::side_t                               s1_side_r;
  logic [mwm_pkg::NWHEEL-1:0][WW-1:0]           s1_w_r;
  logic signed [WW-1:0]                         x_e, y_e, z_e;

  assign x_e = WW'(vel_x);
  assign y_e = WW'(vel_y);
  assign z_e = WW'(yaw_rate);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_side_r.valid <= 1'b0;
    end else begin
      s1_side_r.valid <= in_take;
    end
    s1_side_r.neg    <= '0;
    s1_side_r.moving <= (vel_x > 0);
    s1_w_r[0]        <= x_e - y_e - z_e;
    s1_w_r[1]        <= x_e + y_e + z_e;
    s1_w_r[2]        <= x_e + y_e - z_e;
    s1_w_r[3]        <= x_e - y_e + z_e;
  end

  // stage 2: sign and magnitude per wheel
  mwm_pkg::side_t                               s2_side_r;
  logic [mwm_pkg::NWHEEL-1:0][MW-1:0]           s2_mag_r;
  logic [mwm_pkg::NWHEEL-1:0][MW-1:0]           mag_nxt;
  logic [mwm_pkg::NWHEEL-1:0]                   neg_nxt;
  logic [WW-1:0]                                abs_v [mwm_pkg::NWHEEL];

  always_comb begin
    for (int i = 0; i < mwm_pkg::NWHEEL; i++) begin
      neg_nxt[i] = s1_w_r[i][WW-1];
      abs_v[i]   = neg_nxt[i] ? (~s1_w_r[i] + WW'(1)) : s1_w_r[i];
      mag_nxt[i] = abs_v[i][MW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_side_r.valid <= 1'b0;
    end else begin
      s2_side_r.valid <= s1_side_r.valid;
    end
    s2_side_r.neg    <= neg_nxt;
    s2_side_r.moving <= s1_side_r.moving;
    s2_mag_r         <= mag_nxt;
  end

  // stage 3: peak, divisor choice and scale product
  logic [MW-1:0] pk01, pk23, peak;
  logic [DW-1:0] peak_e;
  logic [DW-1:0] div_nxt;
  logic [mwm_pkg::NWHEEL-1:0][PW-1:0] prod_nxt;

  always_comb begin
    pk01    = (s2_mag_r[0] > s2_mag_r[1]) ? s2_mag_r[0] : s2_mag_r[1];
    pk23    = (s2_mag_r[2] > s2_mag_r[3]) ? s2_mag_r[2] : s2_mag_r[3];
    peak    = (pk01 > pk23) ? pk01 : pk23;
    peak_e  = DW'(peak);
    // normalize only when the peak is strictly above 1.0
    div_nxt = (peak_e > ONE) ? peak_e : ONE;
    for (int i = 0; i < mwm_pkg::NWHEEL; i++) begin
      prod_nxt[i] = PW'(s2_mag_r[i]) * PW'(speed_scale);
    end
  end

  // the high product bits seed the remainder, the low bits feed the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o.valid <= 1'b0;
    end else begin
      side_o.valid <= s2_side_r.valid;
    end
    side_o.neg    <= s2_side_r.neg;
    side_o.moving <= s2_side_r.moving;
    div_o         <= div_nxt;
    for (int i = 0; i < mwm_pkg::NWHEEL; i++) begin
      rem_o[i] <= DW'(prod_nxt[i][PW-1:mwm_pkg::SCALE_W]);
      lo_o[i]  <= prod_nxt[i][mwm_pkg::SCALE_W-1:0];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mwm_div_step.sv -----
// ----------------------------------------------------------------------------
// mwm_div_step
// One registered restoring-division step for all four wheels.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_div_step #(
  parameter int DW = 17
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst_n,
  input  wire mwm_pkg::side_t                              side_i,
  input  wire logic [DW-1:0]                               div_i,
  input  wire logic [mwm_pkg::NWHEEL-1:0][DW-1:0]          rem_i,
  input  wire logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::SCALE_W-1:0] lo_i,
  output mwm_pkg::side_t                                   side_o,
  output logic [DW-1:0]                                    div_o,
  output logic [mwm_pkg::NWHEEL-1:0][DW-1:0]               rem_o,
  output logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::SCALE_W-1:0] lo_o
);

  localparam int QW = mwm_pkg::SCALE_W;

  logic [DW:0]                              trial [mwm_pkg::NWHEEL];
  logic [DW:0]                              diff  [mwm_pkg::NWHEEL];
  logic [mwm_pkg::NWHEEL-1:0]               ge;
  logic [mwm_pkg::NWHEEL-1:0][DW-1:0]       rem_nxt;
  logic [mwm_pkg::NWHEEL-1:0][QW-1:0]       lo_nxt;

  // shift in the next dividend bit, subtract when it fits
  always_comb begin
    for (int i = 0; i < mwm_pkg::NWHEEL; i++) begin
      trial[i]   = {rem_i[i], lo_i[i][QW-1]};
      diff[i]    = trial[i] - {1'b0, div_i};
      ge[i]      = (trial[i] >= {1'b0, div_i});
      rem_nxt[i] = ge[i] ? diff[i][DW-1:0] : trial[i][DW-1:0];
      lo_nxt[i]  = {lo_i[i][QW-2:0], ge[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_o.valid <= 1'b0;
    end else begin
      side_o.valid <= side_i.valid;
    end
    side_o.neg    <= side_i.neg;
    side_o.moving <= side_i.moving;
    div_o         <= div_i;
    rem_o         <= rem_nxt;
    lo_o          <= lo_nxt;
  end

endmodule

`default_nettype wire

// ----- rtl/mwm_shape.sv -----
// ----------------------------------------------------------------------------
// mwm_shape
// Output stage: dead-band offset, duty clamp and direction flags.
// ----------------------------------------------------------------------------
`default_nettype none

module mwm_shape (
  input  wire logic                                            clk,
  input  wire logic                                            rst_n,
  input  wire mwm_pkg::side_t                                  side_i,
  input  wire logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::SCALE_W-1:0] quo_i,
  input  wire logic [mwm_pkg::DUTY_W-1:0]                      dead_offset,
  input  wire logic [mwm_pkg::DUTY_W-1:0]                      duty_limit,
  output logic                                                 valid_o,
  output logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0]      duty_o,
  output logic [mwm_pkg::NWHEEL-1:0]                           fwd_o,
  output logic                                                 moving_o
);

  localparam int QW = mwm_pkg::SCALE_W;

  logic [QW:0]                                       sum   [mwm_pkg::NWHEEL];
  logic [mwm_pkg::DUTY_W-1:0]                        sat   [mwm_pkg::NWHEEL];
  logic [mwm_pkg::NWHEEL-1:0]                        nz;
  logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0]   duty_nxt;
  logic [mwm_pkg::NWHEEL-1:0]                        fwd_nxt;

  // offset away from zero, then clamp to the limit
  always_comb begin
    for (int i = 0; i < mwm_pkg::NWHEEL; i++) begin
      nz[i]       = (quo_i[i] != '0);
      sum[i]      = {1'b0, quo_i[i]} + (QW+1)'(dead_offset);
      sat[i]      = (sum[i] > (QW+1)'(duty_limit)) ? duty_limit
                                                   : sum[i][mwm_pkg::DUTY_W-1:0];
      duty_nxt[i] = nz[i] ? sat[i] : '0;
      fwd_nxt[i]  = nz[i] && !side_i.neg[i] && (duty_limit != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= side_i.valid;
    end
  end

  always_ff @(posedge clk) begin
    duty_o   <= duty_nxt;
    fwd_o    <= fwd_nxt;
    moving_o <= side_i.moving;
  end

endmodule

`default_nettype wire

// ----- rtl/mecanum_wheel_mixer.sv -----
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer
// Mecanum inverse kinematics: velocity command to four wheel duties.
// ----------------------------------------------------------------------------
// pipeline: 16 register stages (3 front-end, 12 divider, 1 output stage)
// throughput: one item per cycle, busy is always low; the receiver cannot stall
// reset: synchronous active-low rst_n clears all valid bits and loads
// speed_scale 1000, dead_offset 40, duty_limit 250
`default_nettype none

module mecanum_wheel_mixer #(
  parameter int IN_WIDTH  = mwm_pkg::IN_WIDTH_DEF,
  parameter int FRAC_BITS = mwm_pkg::FRAC_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // command channel
  input  wire logic                               start,
  output logic                                    busy,
  input  wire logic signed [IN_WIDTH-1:0]         in_vel_x,
  input  wire logic signed [IN_WIDTH-1:0]         in_vel_y,
  input  wire logic signed [IN_WIDTH-1:0]         in_yaw_rate,
  // result channel
  output logic                                    out_valid,
  output logic [mwm_pkg::DUTY_W-1:0]              out_duty_front_left,
  output logic                                    out_fwd_front_left,
  output logic [mwm_pkg::DUTY_W-1:0]              out_duty_front_right,
  output logic                                    out_fwd_front_right,
  output logic [mwm_pkg::DUTY_W-1:0]              out_duty_rear_left,
  output logic                                    out_fwd_rear_left,
  output logic [mwm_pkg::DUTY_W-1:0]              out_duty_rear_right,
  output logic                                    out_fwd_rear_right,
  output logic                                    out_moving_forward,
  // configuration channel
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [mwm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [mwm_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int MW = IN_WIDTH + 1;
  localparam int DW = (IN_WIDTH + 1 > FRAC_BITS + 1) ? IN_WIDTH + 1 : FRAC_BITS + 1;
  localparam int QW = mwm_pkg::SCALE_W;

  // the pipeline never stalls
  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // configuration registers
  logic [mwm_pkg::SCALE_W-1:0] speed_scale_r;
  logic [mwm_pkg::DUTY_W-1:0]  dead_offset_r;
  logic [mwm_pkg::DUTY_W-1:0]  duty_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_scale_r <= mwm_pkg::SPEED_SCALE_RST;
      dead_offset_r <= mwm_pkg::DEAD_OFFSET_RST;
      duty_limit_r  <= mwm_pkg::DUTY_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mwm_pkg::REG_SPEED_SCALE: speed_scale_r <= cfg_data[mwm_pkg::SCALE_W-1:0];
        mwm_pkg::REG_DEAD_OFFSET: dead_offset_r <= cfg_data[mwm_pkg::DUTY_W-1:0];
        mwm_pkg::REG_DUTY_LIMIT:  duty_limit_r  <= cfg_data[mwm_pkg::DUTY_W-1:0];
        default: ;
      endcase
    end
  end

  // divider pipeline links, index 0 is the front-end output
  mwm_pkg::side_t                                side_s [QW+1];
  logic [DW-1:0]                                 div_s  [QW+1];
  logic [mwm_pkg::NWHEEL-1:0][DW-1:0]            rem_s  [QW+1];
  logic [mwm_pkg::NWHEEL-1:0][QW-1:0]            lo_s   [QW+1];

  // front end: sums, magnitudes, peak and products
  mwm_mix #(
    .IN_WIDTH  (IN_WIDTH),
    .FRAC_BITS (FRAC_BITS),
    .MW        (MW),
    .DW        (DW)
  ) u_mix (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_take     (start && !busy),
    .vel_x       (in_vel_x),
    .vel_y       (in_vel_y),
    .yaw_rate    (in_yaw_rate),
    .speed_scale (speed_scale_r),
    .side_o      (side_s[0]),
    .div_o       (div_s[0]),
    .rem_o       (rem_s[0]),
    .lo_o        (lo_s[0])
  );

  // one quotient bit per stage
  for (genvar k = 0; k < QW; k++) begin : g_div
    mwm_div_step #(
      .DW (DW)
    ) u_step (
      .clk    (clk),
      .rst_n  (rst_n),
      .side_i (side_s[k]),
      .div_i  (div_s[k]),
      .rem_i  (rem_s[k]),
      .lo_i   (lo_s[k]),
      .side_o (side_s[k+1]),
      .div_o  (div_s[k+1]),
      .rem_o  (rem_s[k+1]),
      .lo_o   (lo_s[k+1])
    );
  end

  // offset, clamp and output register
  logic [mwm_pkg::NWHEEL-1:0][mwm_pkg::DUTY_W-1:0] duty;
  logic [mwm_pkg::NWHEEL-1:0]                      fwd;

  mwm_shape u_shape (
    .clk         (clk),
    .rst_n       (rst_n),
    .side_i      (side_s[QW]),
    .quo_i       (lo_s[QW]),
    .dead_offset (dead_offset_r),
    .duty_limit  (duty_limit_r),
    .valid_o     (out_valid),
    .duty_o      (duty),
    .fwd_o       (fwd),
    .moving_o    (out_moving_forward)
  );

  assign out_duty_front_left  = duty[0];
  assign out_fwd_front_left   = fwd[0];
  assign out_duty_front_right = duty[1];
  assign out_fwd_front_right  = fwd[1];
  assign out_duty_rear_left   = duty[2];
  assign out_fwd_rear_left    = fwd[2];
  assign out_duty_rear_right  = duty[3];
  assign out_fwd_rear_right   = fwd[3];

endmodule

`default_nettype wire

// ----- tb/mecanum_wheel_mixer_tb.sv -----
// ----------------------------------------------------------------------------
// mecanum_wheel_mixer_tb
// Drives velocity commands into the wheel mixer and checks every set of wheel
// duties against a behavioral mixing model in this bench or typed row values.
// A short table of corner commands runs first, then random commands under
// several register settings, with random sender gaps and quiet stretches.
// ----------------------------------------------------------------------------
module mecanum_wheel_mixer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int VW             = mwm_pkg::IN_WIDTH_DEF;
  localparam int FB             = mwm_pkg::FRAC_BITS_DEF;
  localparam int NW             = mwm_pkg::NWHEEL;
  localparam int DTW            = mwm_pkg::DUTY_W;
  localparam int SCW            = mwm_pkg::SCALE_W;
  localparam int IXW            = mwm_pkg::CFG_IDX_W;
  localparam int CDW            = mwm_pkg::CFG_DATA_W;
  localparam int ONE_Q          = 1 << FB;
  localparam int CLK_PERIOD     = 10;
  localparam int RESET_CYCLES   = 10;
  localparam int DRAIN_CYCLES   = 24;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DIR_N          = 23;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 235;
  localparam int MAX_PRINTS     = 50;

  // index with no register behind it, writes to it are dropped
  localparam logic [IXW-1:0] REG_UNUSED = 2'd3;

  // one full set of wheel outputs
  typedef struct packed {
    logic [NW-1:0][DTW-1:0] duty;
    logic [NW-1:0]          fwd;
    logic                   moving;
  } wheel_set_t;

  // one row of the corner command table
  typedef struct {
    logic signed [VW-1:0] x;
    logic signed [VW-1:0] y;
    logic signed [VW-1:0] z;
    bit                   known;
    wheel_set_t           want;
  } cmd_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 start = 1'b0;
  logic                 busy;
  logic signed [VW-1:0] in_vel_x = '0;
  logic signed [VW-1:0] in_vel_y = '0;
  logic signed [VW-1:0] in_yaw_rate = '0;
  logic                 out_valid;
  logic [DTW-1:0]       out_duty_front_left;
  logic                 out_fwd_front_left;
  logic [DTW-1:0]       out_duty_front_right;
  logic                 out_fwd_front_right;
  logic [DTW-1:0]       out_duty_rear_left;
  logic                 out_fwd_rear_left;
  logic [DTW-1:0]       out_duty_rear_right;
  logic                 out_fwd_rear_right;
  logic                 out_moving_forward;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [IXW-1:0]       cfg_index = '0;
  logic [CDW-1:0]       cfg_data = '0;

  // bench copy of the registers
  logic [SCW-1:0] scale_reg  = mwm_pkg::SPEED_SCALE_RST;
  logic [DTW-1:0] offset_reg = mwm_pkg::DEAD_OFFSET_RST;
  logic [DTW-1:0] limit_reg  = mwm_pkg::DUTY_LIMIT_RST;

  wheel_set_t pending_duties [$];
  cmd_row_t   cmd_table [DIR_N];
  string      wheel_name [NW] = '{"front_left", "front_right", "rear_left", "rear_right"};

  int err_cnt     = 0;
  int n_cmds      = 0;
  int n_results   = 0;
  int n_cfg       = 0;
  int n_scaled_zero = 0;
  int burst_left  = 0;
  int quiet_cycles = 0;

  mecanum_wheel_mixer i_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .start                (start),
    .busy                 (busy),
    .in_vel_x             (in_vel_x),
    .in_vel_y             (in_vel_y),
    .in_yaw_rate          (in_yaw_rate),
    .out_valid            (out_valid),
    .out_duty_front_left  (out_duty_front_left),
    .out_fwd_front_left   (out_fwd_front_left),
    .out_duty_front_right (out_duty_front_right),
    .out_fwd_front_right  (out_fwd_front_right),
    .out_duty_rear_left   (out_duty_rear_left),
    .out_fwd_rear_left    (out_fwd_rear_left),
    .out_duty_rear_right  (out_duty_rear_right),
    .out_fwd_rear_right   (out_fwd_rear_right),
    .out_moving_forward   (out_moving_forward),
    .cfg_valid            (cfg_valid),
    .cfg_ready            (cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // mix one command into four wheel duties under the current registers
  function automatic wheel_set_t mix_wheels(input logic signed [VW-1:0] vx,
                                            input logic signed [VW-1:0] vy,
                                            input logic signed [VW-1:0] vz);
    longint     x, y, z, peak, mag, q, v;
    longint     spd [NW];
    bit         norm;
    int         i;
    wheel_set_t r;
    x = vx;
    y = vy;
    z = vz;
    spd[0] = x - y - z;
    spd[1] = x + y + z;
    spd[2] = x + y - z;
    spd[3] = x - y + z;
    peak = 0;
    for (i = 0; i < NW; i++) begin
      mag = (spd[i] < 0) ? -spd[i] : spd[i];
      if (mag > peak) peak = mag;
    end
    // divide by the peak only when it is strictly above 1.0
    norm = (peak > longint'(ONE_Q));
    for (i = 0; i < NW; i++) begin
      mag = (spd[i] < 0) ? -spd[i] : spd[i];
      if (norm) q = (mag * longint'(scale_reg)) / peak;
      else q = (mag * longint'(scale_reg)) >>> FB;
      v = (spd[i] < 0) ? -q : q;
      // dead band pushes away from zero, clamp comes last
      if (v > 0) v = v + longint'(offset_reg);
      else if (v < 0) v = v - longint'(offset_reg);
      if (v > longint'(limit_reg)) v = longint'(limit_reg);
      else if (v < -longint'(limit_reg)) v = -longint'(limit_reg);
      mag = (v < 0) ? -v : v;
      r.duty[i] = mag[DTW-1:0];
      r.fwd[i]  = (v > 0);
    end
    r.moving = (x > 0);
    return r;
  endfunction

  function automatic cmd_row_t mk_row(input int x, input int y, input int z,
                                      input bit known, input logic [DTW-1:0] d,
                                      input logic [NW-1:0] f, input logic m);
    cmd_row_t r;
    r.x = x[VW-1:0];
    r.y = y[VW-1:0];
    r.z = z[VW-1:0];
    r.known = known;
    r.want.duty = {NW{d}};
    r.want.fwd = f;
    r.want.moving = m;
    return r;
  endfunction

  // velocity field biased toward the interesting values
  function automatic logic signed [VW-1:0] rand_velocity();
    int v;
    case ($urandom_range(9))
      0: v = 0;
      1: v = $urandom_range(1) ? ONE_Q : -ONE_Q;
      2: v = (1 << (VW - 1)) - 1;
      3: v = -(1 << (VW - 1));
      4: v = int'($urandom_range(128)) - 64;
      5, 6: v = int'($urandom_range(16383)) - 8192;
      default: v = int'($urandom);
    endcase
    return v[VW-1:0];
  endfunction

  task automatic report_mismatch(input string msg);
    if (err_cnt < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
    err_cnt++;
  endtask

  // drive one command, entered and left at a falling edge
  task automatic send_cmd(input logic signed [VW-1:0] x, input logic signed [VW-1:0] y,
                          input logic signed [VW-1:0] z, input bit known,
                          input wheel_set_t want, input int idle_pct);
    wheel_set_t exp_set;
    // random sender gaps, broken up by bursts without gaps
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      if ($urandom_range(39) == 0) burst_left = $urandom_range(40, 15);
      while ($urandom_range(99) < idle_pct) begin
        start = 1'b0;
        @(negedge clk);
      end
    end
    exp_set = known ? want : mix_wheels(x, y, z);
    start = 1'b1;
    in_vel_x = x;
    in_vel_y = y;
    in_yaw_rate = z;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_duties.push_back(exp_set);
    n_cmds++;
    if (exp_set.duty == '0 && (x != 0 || y != 0 || z != 0)) n_scaled_zero++;
    @(negedge clk);
  endtask

  // stop sending and let every outstanding item come back
  task automatic settle_pipe();
    start = 1'b0;
    while (pending_duties.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IXW-1:0] idx, input logic [CDW-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      mwm_pkg::REG_SPEED_SCALE: scale_reg = data[SCW-1:0];
      mwm_pkg::REG_DEAD_OFFSET: offset_reg = data[DTW-1:0];
      mwm_pkg::REG_DUTY_LIMIT:  limit_reg = data[DTW-1:0];
      default: ;
    endcase
    n_cfg++;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : check_result
    wheel_set_t got, want;
    int i;
    if (rst_n && out_valid) begin
      got.duty[0] = out_duty_front_left;
      got.duty[1] = out_duty_front_right;
      got.duty[2] = out_duty_rear_left;
      got.duty[3] = out_duty_rear_right;
      got.fwd = {out_fwd_rear_right, out_fwd_rear_left, out_fwd_front_right,
                 out_fwd_front_left};
      got.moving = out_moving_forward;
      n_results++;
      if (pending_duties.size() == 0) begin
        report_mismatch("result with no command pending");
      end else begin
        want = pending_duties.pop_front();
        for (i = 0; i < NW; i++) begin
          if (got.duty[i] !== want.duty[i])
            report_mismatch($sformatf("duty_%s got %0d want %0d", wheel_name[i],
                                      got.duty[i], want.duty[i]));
          if (got.fwd[i] !== want.fwd[i])
            report_mismatch($sformatf("fwd_%s got %b want %b", wheel_name[i],
                                      got.fwd[i], want.fwd[i]));
        end
        if (got.moving !== want.moving)
          report_mismatch($sformatf("moving_forward got %b want %b", got.moving,
                                    want.moving));
      end
    end
  end

  // watchdog on cycles where no handshake completes
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: %0d cycles without progress", quiet_cycles);
        $display("[mecanum_wheel_mixer] ERROR");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int p, n, k, pct, xi, yi, zi;
    logic [SCW-1:0] scale_v;
    logic [DTW-1:0] offset_v, limit_v;
    logic signed [VW-1:0] x, y, z;

    // corner commands; typed rows assume the reset register values
    cmd_table[ 0] = mk_row(0, 0, 0,                1,   0, 4'b0000, 0);
    cmd_table[ 1] = mk_row(32767, 0, 0,            1, 250, 4'b1111, 1);
    cmd_table[ 2] = mk_row(-32768, 0, 0,           1, 250, 4'b0000, 0);
    cmd_table[ 3] = mk_row(0, 32767, 0,            1, 250, 4'b0110, 0);
    cmd_table[ 4] = mk_row(0, -32768, 0,           1, 250, 4'b1001, 0);
    cmd_table[ 5] = mk_row(0, 0, 32767,            1, 250, 4'b1010, 0);
    cmd_table[ 6] = mk_row(0, 0, -32768,           1, 250, 4'b0101, 0);
    cmd_table[ 7] = mk_row(1, 0, 0,                1,   0, 4'b0000, 1);
    cmd_table[ 8] = mk_row(32767, 32767, 32767,    1, 250, 4'b1110, 1);
    cmd_table[ 9] = mk_row(-32768, -32768, -32768, 1, 250, 4'b0001, 0);
    cmd_table[10] = mk_row(ONE_Q, 0, 0,            0, 0, 0, 0);
    cmd_table[11] = mk_row(ONE_Q + 1, 0, 0,        0, 0, 0, 0);
    cmd_table[12] = mk_row(2048, 2048, 0,          0, 0, 0, 0);
    cmd_table[13] = mk_row(-ONE_Q, 0, 0,           0, 0, 0, 0);
    cmd_table[14] = mk_row(5, 0, 0,                0, 0, 0, 0);
    cmd_table[15] = mk_row(-5, 3, -2,              0, 0, 0, 0);
    cmd_table[16] = mk_row(0, 0, 1,                0, 0, 0, 0);
    cmd_table[17] = mk_row(-1, -1, -1,             0, 0, 0, 0);
    cmd_table[18] = mk_row(1000, 2000, 1500,       0, 0, 0, 0);
    cmd_table[19] = mk_row(32767, -32768, 0,       0, 0, 0, 0);
    cmd_table[20] = mk_row(21845, -21846, 3855,    0, 0, 0, 0);
    cmd_table[21] = mk_row(-3000, 4095, -1,        0, 0, 0, 0);
    cmd_table[22] = mk_row(0, 1365, 1365,          0, 0, 0, 0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // corner table under reset values
    for (k = 0; k < DIR_N; k++)
      send_cmd(cmd_table[k].x, cmd_table[k].y, cmd_table[k].z, cmd_table[k].known,
               cmd_table[k].want, 22);

    // random phases, each under its own register setting
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: begin scale_v = 12'd1000; offset_v = 8'd40;  limit_v = 8'd250; end
        1: begin scale_v = 12'd4095; offset_v = 8'd0;   limit_v = 8'd255; end
        2: begin scale_v = 12'd0;    offset_v = 8'd255; limit_v = 8'd255; end
        3: begin scale_v = 12'd200;  offset_v = 8'd30;  limit_v = 8'd120; end
        4: begin scale_v = 12'd4095; offset_v = 8'd255; limit_v = 8'd0;   end
        5: begin scale_v = 12'd1;    offset_v = 8'd1;   limit_v = 8'd255; end
        6: begin scale_v = 12'($urandom); offset_v = 8'($urandom); limit_v = 8'($urandom); end
        default: begin
          scale_v = 12'($urandom_range(4095, 2048)); offset_v = 8'd0;
          limit_v = 8'($urandom_range(255, 128));
        end
      endcase
      pct = (p < 3) ? 22 : (p < 6) ? 49 : 0;
      settle_pipe();
      write_reg(mwm_pkg::REG_SPEED_SCALE, scale_v);
      write_reg(mwm_pkg::REG_DEAD_OFFSET, {4'($urandom), offset_v});
      write_reg(mwm_pkg::REG_DUTY_LIMIT, {4'($urandom), limit_v});
      write_reg(REG_UNUSED, 12'($urandom));

      for (n = 0; n < PHASE_ITEMS; n++) begin
        // hold off mid-phase until the pipeline is empty
        if (p == 3 && n == 100) settle_pipe();
        if ($urandom_range(7) == 0) begin
          // build a command whose front-left wheel lands exactly on +1.0 or -1.0
          yi = int'($urandom_range(16383)) - 8192;
          zi = int'($urandom_range(16383)) - 8192;
          xi = ($urandom_range(1) ? ONE_Q : -ONE_Q) + yi + zi;
          x = xi[VW-1:0];
          y = yi[VW-1:0];
          z = zi[VW-1:0];
        end else begin
          x = rand_velocity();
          y = rand_velocity();
          z = rand_velocity();
        end
        send_cmd(x, y, z, 1'b0, '0, pct);
      end
    end

    settle_pipe();
    $display("covered %0d commands over %0d register settings, %0d register writes",
             n_cmds, PHASES + 1, n_cfg);
    $display("%0d result sets checked, %0d nonzero commands scaled to zero duty",
             n_results, n_scaled_zero);
    if (err_cnt == 0) begin
      $display("[mecanum_wheel_mixer] OK");
    end else begin
      $display("%0d mismatches", err_cnt);
      $display("[mecanum_wheel_mixer] ERROR");
    end
    $finish;
  end

endmodule

// ----- mecanum_wheel_mixer.f -----
rtl/mwm_pkg.sv
rtl/mwm_mix.sv
rtl/mwm_div_step.sv
rtl/mwm_shape.sv
rtl/mecanum_wheel_mixer.sv
tb/mecanum_wheel_mixer_tb.sv
